[sv/prs_pkg.sv]
// ----------------------------------------------------------------------------
// Parameter ramp smoother package
// Shared widths, constants, codes and unit response types.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int VAL_W   = 32;               // Q16.16 value width
   localparam int GUARD_W = 16;               // extra fraction bits of the level
   localparam int LVL_W   = VAL_W + GUARD_W;  // Q16.32 level width
   localparam int DUR_W   = 24;
   localparam int FRAC_W  = 32;               // fraction bits of a log2 value
   localparam int EXP_W   = 6;                // integer bits of a log2 value
   localparam int LOG_W   = EXP_W + FRAC_W;

   localparam int MUL_W      = 64;
   localparam int DIGIT_W    = 4;
   localparam int MUL_STEPS  = MUL_W / DIGIT_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
   localparam int DIV_W      = 64;
   localparam int DVS_W      = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam int TERM_CNT_W = 5;
   localparam logic [TERM_CNT_W-1:0] TAYLOR_TERMS = 5'd24;

   localparam logic signed [LVL_W-1:0] LVL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [LVL_W-1:0] LVL_MIN = 48'sh8000_0000_0000;
   localparam logic [LVL_W-1:0]        MASK48  = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [LVL_W-1:0] EPS_LVL = 48'sh0000_0001_0000;
   localparam logic [DUR_W-1:0]        DUR_MAX = 24'hFF_FFFF;
   localparam logic [FRAC_W-1:0]       LN2_Q32 = 32'hB172_17F8;
   localparam logic [MUL_W-1:0]        ONE_Q62 = 64'h4000_0000_0000_0000;

   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_REQUEST = 2'd1;
   localparam logic [1:0] FUNC_SET     = 2'd2;

   localparam logic [2:0] CSR_MIN_VALUE     = 3'd0;
   localparam logic [2:0] CSR_MAX_VALUE     = 3'd1;
   localparam logic [2:0] CSR_DEFAULT_VALUE = 3'd2;
   localparam logic [2:0] CSR_MODE          = 3'd3;
   localparam logic [2:0] CSR_MIN_EN        = 3'd4;
   localparam logic [2:0] CSR_MIN_DUR       = 3'd5;

   typedef struct packed {
      logic                   done;
      logic [2*MUL_W-1:0]     prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                   done;
      logic [DIV_W-1:0]       quo;
   } div_rsp_type;

endpackage

[sv/prs_mul.sv]
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Unsigned 64 x 64 product, one 4-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module prs_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [prs_pkg::MUL_W-1:0] a,
   input  logic [prs_pkg::MUL_W-1:0] b,
   output prs_pkg::mul_rsp_type     rsp
);
   import prs_pkg::*;

   logic [MUL_W-1:0]         a_ff, a_in, b_ff, b_in;
   logic [2*MUL_W-1:0]       acc_ff, acc_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W+DIGIT_W-1:0] part;
   logic [MUL_W+DIGIT_W:0]   sum;

   always_comb begin
      part    = a_ff * b_ff[DIGIT_W-1:0];
      sum     = {{(DIGIT_W+1){1'b0}}, acc_ff[2*MUL_W-1:MUL_W]} + {1'b0, part};
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Add the digit's partial product at the top, then move right one digit.
         acc_in = {sum[MUL_W+DIGIT_W-1:0], acc_ff[MUL_W-1:DIGIT_W]};
         b_in   = b_ff >> DIGIT_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

[sv/prs_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Unsigned 64 / 32 restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prs_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [prs_pkg::DIV_W-1:0] dividend,
   input  logic [prs_pkg::DVS_W-1:0] divisor,
   output prs_pkg::div_rsp_type     rsp
);
   import prs_pkg::*;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]       rem_t, rem_d;
   logic                 ge;

   always_comb begin
      rem_t   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_t >= {1'b0, dvs_ff};
      rem_d   = rem_t - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The dividend shifts out of the top while quotient bits enter below.
         rem_in = ge ? rem_d[DVS_W-1:0] : rem_t[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

[sv/parameter_ramp_smoother_core.sv]
// ----------------------------------------------------------------------------
// Parameter ramp smoother core
// Per-sample Q16.16 parameter smoother with linear and geometric ramps.
// ----------------------------------------------------------------------------
// Each tick transfer yields one sample transfer; change and set transfers
// yield none. A geometric-ramp tick runs one product in the 4-bit
// digit-serial multiplier, and a linear change request one division in the
// bit-serial divider. A geometric change request runs two base-2 logarithms
// (a normalize shift plus 32 squarings each), one division, 24 Taylor terms
// of one multiply and one division each and a final shift; the multiplies
// and divisions share one multiplier and one divider. The level after reset
// is zero; a write to the default value index is ignored.
module parameter_ramp_smoother_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // new_value [31:0], ramp_length [55:32]
   input  logic [1:0]  req_tuser,   // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample [31:0]
   output logic [0:0]  rsp_tuser,   // ramping [0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import prs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TMUL, ST_EMIT, ST_SDIV, ST_NORM, ST_LSQ, ST_QDIV,
      ST_YMUL, ST_TERM_MUL, ST_TERM_DIV, ST_SHR
   } state_type;

   state_type state_ff;

   logic signed [VAL_W-1:0] min_ff, max_ff;
   logic                    mode_ff, en_ff;
   logic [DUR_W-1:0]        mindur_ff;

   logic                    active_ff;
   logic signed [LVL_W-1:0] cur_ff;
   logic signed [VAL_W-1:0] tgt_ff;
   logic [LVL_W-1:0]        step_ff;
   logic [DUR_W-1:0]        pos_ff, total_ff;

   logic                    neg_ff, phase_ff;
   logic [LVL_W-1:0]        x_ff;
   logic [EXP_W-1:0]        p_ff, shc_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic [4:0]              iter_ff;
   logic [LOG_W-1:0]        lend_ff;
   logic [MUL_W-3:0]        y_ff;
   logic [MUL_W-1:0]        sum_ff;
   logic [TERM_CNT_W-1:0]   k_ff;

   logic                    rsp_valid_ff, ramping_ff;
   logic [VAL_W-1:0]        sample_ff;

   logic                    mul_start_ff, div_start_ff;
   logic                    mul_start_in, div_start_in, rsp_load;
   logic [MUL_W-1:0]        mul_a_ff, mul_b_ff, div_n_ff;
   logic [DVS_W-1:0]        div_d_ff;
   mul_rsp_type             mul_rsp;
   div_rsp_type             div_rsp;

   // Combinational helpers
   logic signed [VAL_W-1:0] nv, lo_t, tgt;
   logic [DUR_W-1:0]        rl, dur;
   logic signed [LVL_W-1:0] tgt48, start_lvl, end_lvl;
   logic signed [LVL_W:0]   diff49, add49;
   logic [LVL_W:0]          diff_mag;
   logic [DUR_W-1:0]        pos_nx;
   logic signed [LVL_W-1:0] add_sat;
   logic [LVL_W-1:0]        cur_mag;
   logic [MUL_W-1:0]        tres;
   logic signed [LVL_W-1:0] tick_mul;
   logic [LVL_W:0]          sq;
   logic signed [LVL_W-1:0] step_sat;
   logic                    lsq_bit;
   logic [FRAC_W-1:0]       m_nx, frac_nx;
   logic [LOG_W-1:0]        lval;
   logic [LOG_W:0]          dlog, dlog_mag;
   logic [39:0]             qmag, q40;
   logic signed [7:0]       n8;
   logic [7:0]              shc8;
   logic [MUL_W-1:0]        sum_nx, sum_p1, rr;

   always_comb begin
      nv    = req_tdata[VAL_W-1:0];
      rl    = req_tdata[VAL_W+DUR_W-1:VAL_W];
      lo_t  = (nv < max_ff) ? nv : max_ff;
      tgt   = (lo_t > min_ff) ? lo_t : min_ff;
      dur   = (en_ff && (mindur_ff > rl)) ? mindur_ff : rl;
      tgt48 = {tgt, {GUARD_W{1'b0}}};
      start_lvl = (cur_ff > EPS_LVL) ? cur_ff : EPS_LVL;
      end_lvl   = (tgt48 > EPS_LVL) ? tgt48 : EPS_LVL;

      diff49   = {tgt48[LVL_W-1], tgt48} - {cur_ff[LVL_W-1], cur_ff};
      diff_mag = diff49[LVL_W] ? (LVL_W+1)'(-diff49) : diff49;

      pos_nx = (pos_ff == DUR_MAX) ? pos_ff : pos_ff + 1'b1;
      add49  = {cur_ff[LVL_W-1], cur_ff} + {step_ff[LVL_W-1], step_ff};
      // The sum left the 48-bit range when its two top bits disagree.
      if (add49[LVL_W] != add49[LVL_W-1]) add_sat = add49[LVL_W] ? LVL_MIN : LVL_MAX;
      else                                 add_sat = add49[LVL_W-1:0];

      cur_mag = cur_ff[LVL_W-1] ? LVL_W'(-cur_ff) : cur_ff;
      tres    = mul_rsp.prod[MUL_W+31:32];
      if (cur_ff[LVL_W-1]) begin
         tick_mul = (tres > {16'b0, LVL_MIN}) ? LVL_MIN : LVL_W'(-tres);
      end else begin
         tick_mul = (tres > {17'b0, LVL_MAX[LVL_W-2:0]}) ? LVL_MAX : tres[LVL_W-1:0];
      end

      // Linear step: saturate the quotient magnitude, then apply the sign.
      sq = div_rsp.quo[LVL_W:0];
      if (neg_ff) begin
         step_sat = (sq > {1'b0, LVL_MIN}) ? LVL_MIN : LVL_W'(-sq);
      end else begin
         step_sat = (sq > {1'b0, LVL_MAX}) ? LVL_MAX : sq[LVL_W-1:0];
      end

      // One squaring step of the log mantissa yields one fraction bit.
      lsq_bit = mul_rsp.prod[63];
      m_nx    = lsq_bit ? mul_rsp.prod[63:32] : mul_rsp.prod[62:31];
      frac_nx = {frac_ff[FRAC_W-2:0], lsq_bit};
      lval    = {p_ff, frac_nx};
      dlog     = {1'b0, lend_ff} - {1'b0, lval};
      dlog_mag = dlog[LOG_W] ? (LOG_W+1)'(-dlog) : dlog;

      qmag = div_rsp.quo[39:0];
      q40  = neg_ff ? 40'(-qmag) : qmag;
      n8   = q40[39:32];
      shc8 = 8'd29 - n8;

      sum_nx = sum_ff + div_rsp.quo;
      sum_p1 = sum_ff + 1'b1;
      rr     = {1'b0, sum_p1[MUL_W-1:1]};
   end

   // Start pulses for the shared multiplier and divider, and the output load.
   always_comb begin
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      rsp_load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == FUNC_TICK)
                  mul_start_in = active_ff && (pos_nx < total_ff) && mode_ff;
               if (req_tuser == FUNC_REQUEST)
                  div_start_in = (dur != '0) && !mode_ff;
            end
         end
         ST_NORM:     mul_start_in = x_ff[LVL_W-1];
         ST_LSQ: begin
            mul_start_in = mul_rsp.done && (iter_ff != 5'd31);
            div_start_in = mul_rsp.done && (iter_ff == 5'd31) && phase_ff;
         end
         ST_QDIV:     mul_start_in = div_rsp.done && (n8 < 8'sd16);
         ST_YMUL:     mul_start_in = mul_rsp.done;
         ST_TERM_MUL: div_start_in = mul_rsp.done;
         ST_TERM_DIV: mul_start_in = div_rsp.done && (k_ff != TAYLOR_TERMS);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '0;
         max_ff       <= 32'sd65536;
         mode_ff      <= 1'b0;
         en_ff        <= 1'b0;
         mindur_ff    <= '0;
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         step_ff      <= '0;
         pos_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         // Writes to the default value index are ignored; the level resets to zero.
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_VALUE:     min_ff    <= csr_data;
               CSR_MAX_VALUE:     max_ff    <= csr_data;
               CSR_DEFAULT_VALUE: ;
               CSR_MODE:          mode_ff   <= csr_data[0];
               CSR_MIN_EN:        en_ff     <= csr_data[0];
               CSR_MIN_DUR:       mindur_ff <= csr_data[DUR_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  case (req_tuser)
                     FUNC_TICK: begin
                        if (active_ff) begin
                           pos_ff <= pos_nx;
                           if (pos_nx >= total_ff) begin
                              cur_ff    <= {tgt_ff, {GUARD_W{1'b0}}};
                              active_ff <= 1'b0;
                              state_ff  <= ST_EMIT;
                           end else if (!mode_ff) begin
                              cur_ff   <= add_sat;
                              state_ff <= ST_EMIT;
                           end else begin
                              mul_a_ff <= {16'b0, cur_mag};
                              mul_b_ff <= {16'b0, step_ff};
                              state_ff <= ST_TMUL;
                           end
                        end else begin
                           state_ff <= ST_EMIT;
                        end
                     end
                     FUNC_REQUEST: begin
                        if (dur == '0) begin
                           cur_ff    <= tgt48;
                           active_ff <= 1'b0;
                        end else begin
                           active_ff <= 1'b1;
                           tgt_ff    <= tgt;
                           total_ff  <= dur;
                           pos_ff    <= '0;
                           div_d_ff  <= {8'b0, dur};
                           if (!mode_ff) begin
                              neg_ff   <= diff49[LVL_W];
                              div_n_ff <= {15'b0, diff_mag};
                              state_ff <= ST_SDIV;
                           end else begin
                              cur_ff   <= start_lvl;
                              x_ff     <= end_lvl;
                              p_ff     <= EXP_W'(LVL_W - 1);
                              phase_ff <= 1'b0;
                              state_ff <= ST_NORM;
                           end
                        end
                     end
                     FUNC_SET: begin
                        cur_ff    <= tgt48;
                        active_ff <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_TMUL: begin
               if (mul_rsp.done) begin
                  cur_ff   <= tick_mul;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  sample_ff    <= cur_ff[LVL_W-1:GUARD_W];
                  ramping_ff   <= active_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SDIV: begin
               if (div_rsp.done) begin
                  step_ff  <= step_sat;
                  state_ff <= ST_IDLE;
               end
            end
            ST_NORM: begin
               if (x_ff[LVL_W-1]) begin
                  frac_ff      <= '0;
                  iter_ff      <= '0;
                  mul_a_ff     <= {32'b0, x_ff[LVL_W-1:GUARD_W]};
                  mul_b_ff     <= {32'b0, x_ff[LVL_W-1:GUARD_W]};
                  state_ff     <= ST_LSQ;
               end else begin
                  x_ff <= x_ff << 1;
                  p_ff <= p_ff - 1'b1;
               end
            end
            ST_LSQ: begin
               if (mul_rsp.done) begin
                  frac_ff <= frac_nx;
                  iter_ff <= iter_ff + 1'b1;
                  if (iter_ff == 5'd31) begin
                     if (!phase_ff) begin
                        // End point done; now the start point, held in the level.
                        lend_ff  <= lval;
                        x_ff     <= cur_ff;
                        p_ff     <= EXP_W'(LVL_W - 1);
                        phase_ff <= 1'b1;
                        state_ff <= ST_NORM;
                     end else begin
                        neg_ff       <= dlog[LOG_W];
                        div_n_ff     <= {25'b0, dlog_mag};
                        state_ff     <= ST_QDIV;
                     end
                  end else begin
                     mul_a_ff     <= {32'b0, m_nx};
                     mul_b_ff     <= {32'b0, m_nx};
                  end
               end
            end
            ST_QDIV: begin
               if (div_rsp.done) begin
                  if (n8 >= 8'sd16) begin
                     step_ff  <= MASK48;
                     state_ff <= ST_IDLE;
                  end else begin
                     shc_ff       <= shc8[EXP_W-1:0];
                     mul_a_ff     <= {32'b0, q40[31:0]};
                     mul_b_ff     <= {32'b0, LN2_Q32};
                     state_ff     <= ST_YMUL;
                  end
               end
            end
            ST_YMUL: begin
               if (mul_rsp.done) begin
                  y_ff         <= mul_rsp.prod[MUL_W-1:2];
                  sum_ff       <= ONE_Q62;
                  k_ff         <= TERM_CNT_W'(1);
                  mul_a_ff     <= ONE_Q62;
                  mul_b_ff     <= {2'b0, mul_rsp.prod[MUL_W-1:2]};
                  state_ff     <= ST_TERM_MUL;
               end
            end
            ST_TERM_MUL: begin
               if (mul_rsp.done) begin
                  div_n_ff     <= mul_rsp.prod[125:62];
                  div_d_ff     <= {27'b0, k_ff};
                  state_ff     <= ST_TERM_DIV;
               end
            end
            ST_TERM_DIV: begin
               if (div_rsp.done) begin
                  sum_ff <= sum_nx;
                  if (k_ff == TAYLOR_TERMS) begin
                     state_ff <= ST_SHR;
                  end else begin
                     k_ff         <= k_ff + 1'b1;
                     mul_a_ff     <= div_rsp.quo;
                     mul_b_ff     <= {2'b0, y_ff};
                     state_ff     <= ST_TERM_MUL;
                  end
               end
            end
            ST_SHR: begin
               // Scale by 2^n one bit a cycle, then round half up.
               if (shc_ff == '0) begin
                  step_ff  <= (rr > {16'b0, MASK48}) ? MASK48 : rr[LVL_W-1:0];
                  state_ff <= ST_IDLE;
               end else begin
                  sum_ff <= sum_ff >> 1;
                  shc_ff <= shc_ff - 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   prs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .rsp   (mul_rsp)
   );

   prs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .rsp      (div_rsp)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = sample_ff;
   assign rsp_tuser[0] = ramping_ff;

endmodule
